[src/fep_pkg.sv]
// ----------------------------------------------------------------------------
// fep_pkg: shared types and constants for the field element bit packer
// Widths of the stream fields, the bit accumulator and the result group.
// ----------------------------------------------------------------------------
package fep_pkg;

  localparam int ELEM_W  = 12;  // widest field element / data word
  localparam int BYTE_W  = 8;
  localparam int ACC_W   = 20;  // bit accumulator
  localparam int HELD_W  = 5;   // count of bits held
  localparam int MBITS_W = 4;   // element width register
  localparam int MAX_RES = 3;   // results one input item can cause
  localparam int CNT_W   = 2;   // holds 0..MAX_RES

  localparam logic [MBITS_W-1:0] M_MIN   = 4'd8;
  localparam logic [MBITS_W-1:0] M_MAX   = 4'd12;
  localparam logic [MBITS_W-1:0] M_RESET = 4'd10;

  // Register indexes on the configuration port
  localparam logic REG_PACK_DIR  = 1'b0;
  localparam logic REG_ELEM_BITS = 1'b1;

  // Results produced by one input item, emitted in order from index 0
  typedef struct packed {
    logic [CNT_W-1:0]              cnt;
    logic                          fin;
    logic [MAX_RES-1:0][ELEM_W-1:0] vals;
  } res_grp_t;

endpackage

[src/field_element_bit_packer.sv]
// ----------------------------------------------------------------------------
// field_element_bit_packer: MSB-first converter between bytes and m-bit elements
// The first result of an item is offered in the cycle after its transfer.
// Throughput: one result per cycle while out_tready is high. A new item is
// taken when no result is held or as the last held one transfers, so
// unpacking runs at one item per cycle when the output does not stall.
// The rate is set by the single output serializer draining each result group.
// Reset (synchronous, rst_n low) empties the accumulator and output and loads
// the configuration defaults: unpack, 10-bit elements.
// ----------------------------------------------------------------------------
module field_element_bit_packer
  import fep_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [11:0] data_in, [15:12] unused
  input  logic        in_tlast,    // final_item
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [11:0] data_out, [15:12] zero
  output logic        out_tlast,   // run_end
  output logic        out_tuser,   // stream_end
  // configuration port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic               pack_dir_r;
  logic [MBITS_W-1:0] elem_bits_r;
  logic [ACC_W-1:0]   acc_r;
  logic [ACC_W-1:0]   acc_nxt;
  logic [HELD_W-1:0]  held_r;
  logic [HELD_W-1:0]  held_nxt;
  res_grp_t           grp;
  logic               can_load;
  logic               in_fire;
  logic               cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign in_tready  = can_load;
  assign in_fire    = in_tvalid && can_load;

  always_comb begin
    case (cfg_paddr[2])
      REG_PACK_DIR:  cfg_prdata = {31'b0, pack_dir_r};
      REG_ELEM_BITS: cfg_prdata = {{(32-MBITS_W){1'b0}}, elem_bits_r};
      default:       cfg_prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pack_dir_r  <= 1'b0;
      elem_bits_r <= M_RESET;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        REG_PACK_DIR:  pack_dir_r  <= cfg_pwdata[0];
        REG_ELEM_BITS: elem_bits_r <= cfg_pwdata[MBITS_W-1:0];
        default:       pack_dir_r  <= pack_dir_r;
      endcase
    end
  end

  // Any configuration write discards a partly collected stream.
  always_ff @(posedge clk) begin
    if (!rst_n || cfg_wr) begin
      acc_r  <= '0;
      held_r <= '0;
    end else if (in_fire) begin
      acc_r  <= acc_nxt;
      held_r <= held_nxt;
    end
  end

  fep_calc u_calc (
    .pack_dir   (pack_dir_r),
    .elem_bits  (elem_bits_r),
    .acc        (acc_r),
    .held       (held_r),
    .data_in    (in_tdata[ELEM_W-1:0]),
    .final_item (in_tlast),
    .grp        (grp),
    .acc_nxt    (acc_nxt),
    .held_nxt   (held_nxt)
  );

  fep_outbuf u_outbuf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (in_fire),
    .grp        (grp),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

[src/fep_calc.sv]
// ----------------------------------------------------------------------------
// fep_calc: accumulator update for one input item
// Appends the item to the bit accumulator and splits off every complete
// element or byte, plus, when packing, the zero-padded flush byte on the final item.
// ----------------------------------------------------------------------------
module fep_calc
  import fep_pkg::*;
(
  input  logic               pack_dir,
  input  logic [MBITS_W-1:0] elem_bits,
  input  logic [ACC_W-1:0]   acc,
  input  logic [HELD_W-1:0]  held,
  input  logic [ELEM_W-1:0]  data_in,
  input  logic               final_item,
  output res_grp_t           grp,
  output logic [ACC_W-1:0]   acc_nxt,
  output logic [HELD_W-1:0]  held_nxt
);

  logic [MBITS_W-1:0] m;
  logic [HELD_W-1:0]  m5;
  logic [ELEM_W-1:0]  mask_m;
  logic [ACC_W-1:0]   acc1;
  logic [HELD_W-1:0]  h;
  logic [BYTE_W-1:0]  flush_byte;

  always_comb begin
    if (elem_bits < M_MIN) begin
      m = M_MIN;
    end else if (elem_bits > M_MAX) begin
      m = M_MAX;
    end else begin
      m = elem_bits;
    end
    m5     = {1'b0, m};
    mask_m = ELEM_W'((13'(1) << m) - 13'(1));

    grp.cnt  = '0;
    grp.fin  = final_item;
    grp.vals = '0;
    flush_byte = '0;

    if (!pack_dir) begin
      // Unpack: held stays below m, so one byte gives at most one element.
      acc1 = {acc[ACC_W-BYTE_W-1:0], data_in[BYTE_W-1:0]};
      h    = held + HELD_W'(BYTE_W);
      if (h >= m5) begin
        h           = h - m5;
        grp.vals[0] = ELEM_W'(acc1 >> h) & mask_m;
        grp.cnt     = CNT_W'(1);
      end
    end else begin
      // Pack: held stays below 8, so one element gives at most two bytes.
      acc1 = (acc << m) | {{(ACC_W-ELEM_W){1'b0}}, data_in & mask_m};
      h    = held + m5;
      if (h >= HELD_W'(BYTE_W)) begin
        h           = h - HELD_W'(BYTE_W);
        grp.vals[0] = {{(ELEM_W-BYTE_W){1'b0}}, BYTE_W'(acc1 >> h)};
        grp.cnt     = CNT_W'(1);
      end
      if (h >= HELD_W'(BYTE_W)) begin
        h           = h - HELD_W'(BYTE_W);
        grp.vals[1] = {{(ELEM_W-BYTE_W){1'b0}}, BYTE_W'(acc1 >> h)};
        grp.cnt     = CNT_W'(2);
      end
      // Leftover bits go out at the top of one byte, zeros below.
      flush_byte = BYTE_W'(acc1 << (HELD_W'(BYTE_W) - h));
      if (final_item && h != '0) begin
        case (grp.cnt)
          2'd0:    grp.vals[0] = {{(ELEM_W-BYTE_W){1'b0}}, flush_byte};
          2'd1:    grp.vals[1] = {{(ELEM_W-BYTE_W){1'b0}}, flush_byte};
          default: grp.vals[2] = {{(ELEM_W-BYTE_W){1'b0}}, flush_byte};
        endcase
        grp.cnt = grp.cnt + CNT_W'(1);
      end
    end

    if (final_item) begin
      acc_nxt  = '0;
      held_nxt = '0;
    end else begin
      acc_nxt  = acc1 & ((ACC_W'(1) << h) - ACC_W'(1));
      held_nxt = h;
    end
  end

endmodule

[src/fep_outbuf.sv]
// ----------------------------------------------------------------------------
// fep_outbuf: result group register and output serializer
// Holds the results of one input item and presents them one per transfer.
// ----------------------------------------------------------------------------
module fep_outbuf
  import fep_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        load,
  input  res_grp_t    grp,
  output logic        can_load,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,   // [11:0] data_out, [15:12] zero
  output logic        out_tlast,   // run_end
  output logic        out_tuser    // stream_end
);

  logic [CNT_W-1:0]               cnt_r;
  logic [CNT_W-1:0]               pos_r;
  logic                           fin_r;
  logic [MAX_RES-1:0][ELEM_W-1:0] vals_r;
  logic                           take;
  logic                           last_one;

  assign out_tvalid = (pos_r != cnt_r);
  assign last_one   = (pos_r == cnt_r - CNT_W'(1));
  assign take       = out_tvalid && out_tready;
  // A new group may load once the held one is gone or its last transfer ends now.
  assign can_load   = !out_tvalid || (take && last_one);

  assign out_tdata  = {{(16-ELEM_W){1'b0}}, vals_r[pos_r]};
  assign out_tlast  = last_one;
  assign out_tuser  = fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      pos_r <= '0;
    end else if (load) begin
      cnt_r <= grp.cnt;
      pos_r <= '0;
    end else if (take) begin
      pos_r <= pos_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      vals_r <= grp.vals;
      fin_r  <= grp.fin;
    end
  end

endmodule

[test/tb_field_element_bit_packer.sv]
// ----------------------------------------------------------------------------
// tb_field_element_bit_packer: self-checking bench for the byte/element packer
// Drives byte and element streams in both directions at every element width,
// predicts each output word from its own copy of the accumulator, and compares
// every output transfer in order, under random and long output stalls.
// ----------------------------------------------------------------------------
module tb_field_element_bit_packer;
  import fep_pkg::*;

  typedef struct {
    logic [ELEM_W-1:0] data;
    logic              run_end;
    logic              stream_end;
  } out_word_t;

  localparam int LONG_HOLD = 300;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [11:0] data_in, [15:12] unused
  logic        in_tlast = 1'b0; // final_item
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // [11:0] data_out, [15:12] zero
  logic        out_tlast;       // run_end
  logic        out_tuser;       // stream_end
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predicted state of the block.
  logic               exp_pack_dir;
  logic [MBITS_W-1:0] exp_elem_bits;
  logic [ACC_W-1:0]   exp_acc;
  logic [HELD_W-1:0]  exp_held;

  out_word_t expected_words[$];
  int        fail_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        hold_requests = 0;
  int        hold_seen = 0;
  int        hold_left = 0;

  field_element_bit_packer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Works out the output words that one accepted input transfer causes.
  task automatic predict_words(input logic [ELEM_W-1:0] word, input logic fin);
    int unsigned       m;
    int                n;
    int                k;
    logic [ELEM_W-1:0] vals [MAX_RES];
    logic [ACC_W-1:0]  mask;
    out_word_t         w;
    m = (exp_elem_bits < M_MIN) ? 8 : (exp_elem_bits > M_MAX) ? 12 : exp_elem_bits;
    n = 0;
    mask = (ACC_W'(1) << m) - ACC_W'(1);
    if (!exp_pack_dir) begin
      exp_acc = (exp_acc << 8) | ACC_W'(word[7:0]);
      exp_held = exp_held + HELD_W'(8);
      if (exp_held >= m) begin
        exp_held = exp_held - HELD_W'(m);
        vals[n] = ELEM_W'((exp_acc >> exp_held) & mask);
        n++;
        exp_acc = exp_acc & ((ACC_W'(1) << exp_held) - ACC_W'(1));
      end
      // Leftover bits of an unpacked stream are simply dropped.
      if (fin) begin
        exp_acc = '0;
        exp_held = '0;
      end
    end else begin
      exp_acc = (exp_acc << m) | (ACC_W'(word) & mask);
      exp_held = exp_held + HELD_W'(m);
      while (exp_held >= 8 && n < 2) begin
        exp_held = exp_held - HELD_W'(8);
        vals[n] = ELEM_W'((exp_acc >> exp_held) & ACC_W'(8'hFF));
        n++;
        exp_acc = exp_acc & ((ACC_W'(1) << exp_held) - ACC_W'(1));
      end
      if (fin) begin
        // Remaining bits go out as one byte padded with zeros at the bottom.
        if (exp_held != 0) begin
          vals[n] = ELEM_W'(8'(exp_acc << (8 - exp_held)));
          n++;
        end
        exp_acc = '0;
        exp_held = '0;
      end
    end
    for (k = 0; k < n; k++) begin
      w.data = vals[k];
      w.run_end = (k == n - 1);
      w.stream_end = fin;
      expected_words.push_back(w);
    end
  endtask

  task automatic send_item(input logic [ELEM_W-1:0] word, input logic fin);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0000, word};
    in_tlast <= fin;
    do @(posedge clk); while (!in_tready);
    predict_words(word, fin);
  endtask

  // Stops offering input, waits for every predicted word, then keeps waiting
  // with the block idle.
  task automatic wait_results_drained();
    in_tvalid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(input logic reg_idx, input logic [31:0] value);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= {reg_idx, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (reg_idx == REG_PACK_DIR) exp_pack_dir = value[0];
    else exp_elem_bits = value[MBITS_W-1:0];
    // Any register write empties the accumulator.
    exp_acc = '0;
    exp_held = '0;
    @(posedge clk);
  endtask

  task automatic configure_packer(input logic [31:0] dir, input logic [31:0] bits);
    wait_results_drained();
    write_register(REG_PACK_DIR, dir);
    write_register(REG_ELEM_BITS, bits);
  endtask

  task automatic random_config();
    logic [31:0] bits;
    if ($urandom_range(4) == 0) bits = $urandom_range(15);
    else bits = $urandom_range(8, 12);
    configure_packer($urandom_range(1), bits);
  endtask

  task automatic test_directed();
    send_idle_pct = 7;
    recv_stall_pct = 55;
    // Reset settings: unpack into 10-bit elements; bits above the byte ignored.
    send_item(12'h000, 1'b0);
    send_item(12'hFFF, 1'b0);
    send_item(12'h5A5, 1'b0);
    send_item(12'h0C3, 1'b1);
    // Pack 12-bit elements, leftover nibble flushed on the final item.
    configure_packer(32'hFFFF_FFFF, 32'd12);
    send_item(12'hFFF, 1'b0);
    send_item(12'h000, 1'b0);
    send_item(12'h801, 1'b1);
    // Pack 8-bit elements: plain byte copy, final item with nothing to flush.
    configure_packer(32'd1, 32'd8);
    send_item(12'hFAB, 1'b0);
    send_item(12'h000, 1'b1);
    // Widths outside 8..12 act as the nearest end of the range.
    configure_packer(32'd1, 32'd0);
    send_item(12'h7C5, 1'b1);
    configure_packer(32'd1, 32'd13);
    send_item(12'hABC, 1'b1);
    configure_packer(32'hFFFF_FFFE, 32'hFFFF_FFF3);
    send_item(12'h1FF, 1'b0);
    send_item(12'h080, 1'b1);
    // A lone byte at width 12 gives nothing and its bits are dropped.
    configure_packer(32'd0, 32'd15);
    send_item(12'h0AB, 1'b1);
    // A half-built element is discarded by the register write that follows.
    send_item(12'h0CD, 1'b0);
    configure_packer(32'd0, 32'd9);
    send_item(12'h0FF, 1'b0);
    send_item(12'h0FF, 1'b1);
    // Element bits at and above the width are ignored.
    configure_packer(32'd1, 32'd9);
    send_item(12'hE00, 1'b0);
    send_item(12'h1FF, 1'b1);
  endtask

  task automatic test_random_streams(input int n_items, input int sender_idle,
                                     input int receiver_stall);
    int   sent;
    int   len;
    int   i;
    logic cut;
    send_idle_pct = sender_idle;
    recv_stall_pct = receiver_stall;
    sent = 0;
    while (sent < n_items) begin
      if (sent == 0 || $urandom_range(3) == 0) random_config();
      len = $urandom_range(1, 10);
      if (len > n_items - sent) len = n_items - sent;
      cut = ($urandom_range(7) == 0);
      for (i = 0; i < len; i++) begin
        send_item(ELEM_W'($urandom), (i == len - 1) && !cut);
        sent++;
      end
      // A stream left without its final item is ended by a register write.
      if (cut) random_config();
    end
  endtask

  task automatic test_backpressure();
    int i;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    configure_packer(32'd1, 32'd12);
    hold_requests++;
    for (i = 0; i < 24; i++) send_item(ELEM_W'($urandom), i == 23);
    wait_results_drained();
    for (i = 0; i < 6; i++) send_item(ELEM_W'($urandom), i == 5);
  endtask

  // Output side: random stalls, plus one long hold-off on request.
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen <= hold_requests;
      hold_left <= LONG_HOLD;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    out_word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected output transfer: data_out %0h", out_tdata[ELEM_W-1:0]);
        fail_count++;
      end else begin
        want = expected_words.pop_front();
        if (out_tdata[ELEM_W-1:0] !== want.data) begin
          $error("data_out: expected %0h, got %0h", want.data, out_tdata[ELEM_W-1:0]);
          fail_count++;
        end
        if (out_tlast !== want.run_end) begin
          $error("run_end: expected %0b, got %0b", want.run_end, out_tlast);
          fail_count++;
        end
        if (out_tuser !== want.stream_end) begin
          $error("stream_end: expected %0b, got %0b", want.stream_end, out_tuser);
          fail_count++;
        end
      end
    end
  end

  initial begin
    exp_pack_dir = 1'b0;
    exp_elem_bits = M_RESET;
    exp_acc = '0;
    exp_held = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_streams(15, 7, 55);
    test_random_streams(15, 55, 7);
    test_random_streams(16, 0, 0);
    test_backpressure();
    wait_results_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #400000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[sim.f]
src/fep_pkg.sv
src/fep_calc.sv
src/fep_outbuf.sv
src/field_element_bit_packer.sv
test/tb_field_element_bit_packer.sv
